// File: rtl/integer_to_ascii_formatter_core_defines.svh
// Assertion macros shared by the formatter checker.
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off while in reset.
`define I2A_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off while in reset.
`define I2A_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/i2a_pkg.sv
// Shared constants, types and helpers for the integer-to-ASCII formatter.
package i2a_pkg;

    localparam int VALUE_BITS = 32;
    localparam int CMD_W      = 2;
    localparam int CHAR_W     = 8;

    // ceil(VALUE_BITS * log10(2)) decimal digits, ceil(VALUE_BITS / 4) hex digits
    localparam int DEC_DIGITS = (VALUE_BITS * 30103 + 99999) / 100000;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int DIG_W      = DEC_DIGITS * 4;
    localparam int HEX_SHIFT  = (DEC_DIGITS - HEX_DIGITS) * 4;
    localparam int BIT_CNT_W  = $clog2(VALUE_BITS + 1);
    localparam int DIG_CNT_W  = $clog2(DEC_DIGITS + 1);

    localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

    typedef enum logic [CMD_W-1:0] {
        FMT_SDEC   = 2'd0,
        FMT_UDEC   = 2'd1,
        FMT_HEX_LO = 2'd2,
        FMT_HEX_UP = 2'd3
    } fmt_t;

    typedef enum logic [1:0] {
        CV_IDLE,
        CV_RUN,
        CV_FULL
    } conv_state_t;

    typedef enum logic [1:0] {
        EM_IDLE,
        EM_SKIP,
        EM_OUT
    } emit_state_t;

    // Converted digit set handed from converter to emitter
    typedef struct packed {
        logic [DIG_W-1:0] digits;
        logic             neg;
        logic             hex;
        logic             upper;
    } digits_t;

    function automatic logic [CHAR_W-1:0] nib_to_char(input logic [3:0] nib,
                                                      input logic upper);
        logic [CHAR_W-1:0] base;
        base = upper ? CHAR_UPPER_A : CHAR_LOWER_A;
        if (nib < 4'd10) begin
            return CHAR_ZERO + {4'd0, nib};
        end
        return base + {4'd0, nib} - 8'd10;
    endfunction

endpackage

// File: rtl/i2a_conv.sv
// Sign handling and bit-serial binary-to-BCD (shift-add-3) converter; hex words bypass the conversion.
module i2a_conv (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [i2a_pkg::CMD_W-1:0]         in_cmd,
    input  logic [i2a_pkg::VALUE_BITS-1:0]    in_value,
    output logic                              out_valid,
    input  logic                              out_take,
    output i2a_pkg::digits_t                  out_data
);

    localparam int VB = i2a_pkg::VALUE_BITS;
    localparam int DW = i2a_pkg::DIG_W;
    localparam int CW = i2a_pkg::BIT_CNT_W;

    i2a_pkg::conv_state_t state_reg, state_next;
    logic [VB-1:0] mag_reg, mag_next;
    logic [DW-1:0] bcd_reg, bcd_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          neg_reg, neg_next;
    logic          hex_reg, hex_next;
    logic          upper_reg, upper_next;

    i2a_pkg::fmt_t fmt;
    logic          in_neg;
    logic [VB-1:0] in_mag;
    logic [DW-1:0] bcd_adj;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= i2a_pkg::CV_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        mag_reg   <= mag_next;
        bcd_reg   <= bcd_next;
        cnt_reg   <= cnt_next;
        neg_reg   <= neg_next;
        hex_reg   <= hex_next;
        upper_reg <= upper_next;
    end

    always_comb begin
        for (int i = 0; i < i2a_pkg::DEC_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                bcd_adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_comb begin
        fmt    = i2a_pkg::fmt_t'(in_cmd);
        in_neg = (fmt == i2a_pkg::FMT_SDEC) && in_value[VB-1];
        in_mag = in_neg ? (~in_value + {{(VB-1){1'b0}}, 1'b1}) : in_value;

        state_next = state_reg;
        mag_next   = mag_reg;
        bcd_next   = bcd_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        hex_next   = hex_reg;
        upper_next = upper_reg;
        in_ready   = 1'b0;
        out_valid  = 1'b0;

        case (state_reg)
            i2a_pkg::CV_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    neg_next   = in_neg;
                    hex_next   = (fmt == i2a_pkg::FMT_HEX_LO) || (fmt == i2a_pkg::FMT_HEX_UP);
                    upper_next = (fmt == i2a_pkg::FMT_HEX_UP);
                    mag_next   = in_mag;
                    cnt_next   = CW'(VB);
                    if ((fmt == i2a_pkg::FMT_HEX_LO) || (fmt == i2a_pkg::FMT_HEX_UP)) begin
                        bcd_next   = {{(DW-VB){1'b0}}, in_mag};
                        state_next = i2a_pkg::CV_FULL;
                    end else begin
                        bcd_next   = '0;
                        state_next = i2a_pkg::CV_RUN;
                    end
                end
            end
            i2a_pkg::CV_RUN: begin
                bcd_next = {bcd_adj[DW-2:0], mag_reg[VB-1]};
                mag_next = {mag_reg[VB-2:0], 1'b0};
                cnt_next = cnt_reg - CW'(1);
                if (cnt_reg == CW'(1)) begin
                    state_next = i2a_pkg::CV_FULL;
                end
            end
            i2a_pkg::CV_FULL: begin
                out_valid = 1'b1;
                if (out_take) begin
                    state_next = i2a_pkg::CV_IDLE;
                end
            end
            default: begin
                state_next = i2a_pkg::CV_IDLE;
            end
        endcase
    end

    assign out_data.digits = bcd_reg;
    assign out_data.neg    = neg_reg;
    assign out_data.hex    = hex_reg;
    assign out_data.upper  = upper_reg;

endmodule

// File: rtl/i2a_emit.sv
// Digit emitter: leading-zero skip, one char per cycle to the output reg unless stalled.
module i2a_emit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_take,
    input  i2a_pkg::digits_t              in_data,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [i2a_pkg::CHAR_W-1:0]    m_character,
    output logic                          m_last
);

    localparam int DW = i2a_pkg::DIG_W;
    localparam int NW = i2a_pkg::DIG_CNT_W;

    i2a_pkg::emit_state_t state_reg, state_next;
    logic [DW-1:0]              dig_reg, dig_next;
    logic [NW-1:0]              cnt_reg, cnt_next;
    logic                       neg_reg, neg_next;
    logic                       upper_reg, upper_next;
    logic                       m_valid_reg, m_valid_next;
    logic [i2a_pkg::CHAR_W-1:0] char_reg, char_next;
    logic                       last_reg, last_next;

    logic       out_free;
    logic [3:0] top_nib;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= i2a_pkg::EM_IDLE;
            m_valid_reg <= 1'b0;
            neg_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            neg_reg     <= neg_next;
        end
    end

    always_ff @(posedge aclk) begin
        dig_reg   <= dig_next;
        cnt_reg   <= cnt_next;
        upper_reg <= upper_next;
        char_reg  <= char_next;
        last_reg  <= last_next;
    end

    always_comb begin
        out_free = !m_valid_reg || m_ready;
        top_nib  = dig_reg[DW-1 -: 4];

        state_next   = state_reg;
        dig_next     = dig_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        upper_next   = upper_reg;
        char_next    = char_reg;
        last_next    = last_reg;
        m_valid_next = m_valid_reg && !m_ready;
        in_take      = 1'b0;

        case (state_reg)
            i2a_pkg::EM_IDLE: begin
                if (in_valid) begin
                    in_take    = 1'b1;
                    neg_next   = in_data.neg;
                    upper_next = in_data.upper;
                    if (in_data.hex) begin
                        dig_next = in_data.digits << i2a_pkg::HEX_SHIFT;
                        cnt_next = NW'(i2a_pkg::HEX_DIGITS);
                    end else begin
                        dig_next = in_data.digits;
                        cnt_next = NW'(i2a_pkg::DEC_DIGITS);
                    end
                    state_next = i2a_pkg::EM_SKIP;
                end
            end
            i2a_pkg::EM_SKIP: begin
                if (neg_reg && out_free) begin
                    char_next    = i2a_pkg::CHAR_MINUS;
                    last_next    = 1'b0;
                    m_valid_next = 1'b1;
                    neg_next     = 1'b0;
                end
                if ((top_nib == 4'd0) && (cnt_reg > NW'(1))) begin
                    dig_next = {dig_reg[DW-5:0], 4'd0};
                    cnt_next = cnt_reg - NW'(1);
                end else if (!neg_reg) begin
                    state_next = i2a_pkg::EM_OUT;
                end
            end
            i2a_pkg::EM_OUT: begin
                if (out_free) begin
                    char_next    = i2a_pkg::nib_to_char(top_nib, upper_reg);
                    last_next    = (cnt_reg == NW'(1));
                    m_valid_next = 1'b1;
                    dig_next     = {dig_reg[DW-5:0], 4'd0};
                    cnt_next     = cnt_reg - NW'(1);
                    if (cnt_reg == NW'(1)) begin
                        state_next = i2a_pkg::EM_IDLE;
                    end
                end
            end
            default: begin
                state_next = i2a_pkg::EM_IDLE;
            end
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_character = char_reg;
    assign m_last      = last_reg;

endmodule

// File: rtl/integer_to_ascii_formatter_core.sv
// Top level of the integer-to-ASCII formatter: converter feeding the digit emitter.
//
//   channel  dir  handshake           payload
//   s_       in   s_valid / s_ready   s_cmd[1:0], s_value[31:0]
//   m_       out  m_valid / m_ready   m_character[7:0], m_last
//
// Converter: loads the word, then runs one shift-add-3 step per value bit for decimal, none for hex.
// Emitter: loads the digit set, skips each leading zero while sending any minus sign, then
// leaves the skip and outputs the remaining digits one by one.
// The converter takes the next word while the emitter still drains the last one.
// Reset: aresetn, synchronous, active low; clears both state machines and m_valid.
// m_ready low holds the output register, then the emitter, then the converter.
module integer_to_ascii_formatter_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [i2a_pkg::CMD_W-1:0]         s_cmd,
    input  logic [i2a_pkg::VALUE_BITS-1:0]    s_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [i2a_pkg::CHAR_W-1:0]        m_character,
    output logic                              m_last
);

    logic             dig_valid;
    logic             dig_take;
    i2a_pkg::digits_t dig_data;

    i2a_conv u_conv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_cmd    (s_cmd),
        .in_value  (s_value),
        .out_valid (dig_valid),
        .out_take  (dig_take),
        .out_data  (dig_data)
    );

    i2a_emit u_emit (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (dig_valid),
        .in_take     (dig_take),
        .in_data     (dig_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

endmodule

// File: rtl/i2a_checker.sv
// Port-level checker for the formatter, bound to the top level.
`include "integer_to_ascii_formatter_core_defines.svh"

module i2a_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [i2a_pkg::CHAR_W-1:0]     m_character,
    input logic                           m_last
);

    `I2A_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_character) && $stable(m_last), "stalled result transaction changed")

    `I2A_ASSERT_NEXT(a_in_busy, s_valid && s_ready, !s_ready, "input ready stayed high after a transaction")

    `I2A_ASSERT_NOW(a_minus_not_last, m_valid && (m_character == i2a_pkg::CHAR_MINUS), !m_last, "minus sign marked last")

    `I2A_ASSERT_NOW(a_char_legal, m_valid, (m_character == i2a_pkg::CHAR_MINUS) || ((m_character >= 8'h30) && (m_character <= 8'h39)) || ((m_character >= 8'h41) && (m_character <= 8'h46)) || ((m_character >= 8'h61) && (m_character <= 8'h66)), "illegal output character")

endmodule

bind integer_to_ascii_formatter_core i2a_checker u_i2a_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_character (m_character),
    .m_last      (m_last)
);

// File: test/tb_integer_to_ascii_formatter_core.sv
// Testbench for integer_to_ascii_formatter_core: directed and random words in all formats, checked per character.
module tb_integer_to_ascii_formatter_core;
    import i2a_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 60;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    class char_scoreboard;
        text_char_t expected_q[$];
        int errors;
        int words;
        int chars;

        // Builds the expected text of one accepted word.
        function void note_word(fmt_t fmt, logic [VALUE_BITS-1:0] value);
            logic [VALUE_BITS-1:0] mag;
            logic [CHAR_W-1:0]     rev[$];
            int unsigned           base;
            string                 digit_set;
            words++;
            mag = value;
            if (fmt == FMT_SDEC && value[VALUE_BITS-1]) begin
                expected_q.push_back({CHAR_MINUS, 1'b0});
                mag = -value;
            end
            base = (fmt == FMT_HEX_LO || fmt == FMT_HEX_UP) ? 16 : 10;
            digit_set = (fmt == FMT_HEX_UP) ? "0123456789ABCDEF" : "0123456789abcdef";
            do begin
                rev.push_front(digit_set[mag % base]);
                mag = mag / base;
            end while (mag != 0);
            foreach (rev[i]) begin
                expected_q.push_back({rev[i], i == rev.size() - 1});
            end
        endfunction

        function void check_char(logic [CHAR_W-1:0] ch, logic last);
            text_char_t exp_char;
            chars++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected character: expected none, actual %h last %b",
                         $time, ch, last);
                return;
            end
            exp_char = expected_q.pop_front();
            if (ch !== exp_char.ch) begin
                errors++;
                $display("%0t: character mismatch: expected %h, actual %h",
                         $time, exp_char.ch, ch);
            end
            if (last !== exp_char.last) begin
                errors++;
                $display("%0t: last mismatch: expected %b, actual %b",
                         $time, exp_char.last, last);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_valid;
    logic                  s_ready;
    logic [CMD_W-1:0]      s_cmd;
    logic [VALUE_BITS-1:0] s_value;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    logic [CHAR_W-1:0]     m_character;
    logic                  m_last;

    logic src_idle_en  = 1'b0;
    logic sink_idle_en = 1'b0;
    logic long_hold    = 1'b0;
    int   sink_stall   = 0;
    int   cycle_count  = 0;

    char_scoreboard sb = new;

    integer_to_ascii_formatter_core dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_cmd       (s_cmd),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_character (m_character),
        .m_last      (m_last)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout, %0d characters still outstanding", $time, sb.pending());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            sb.note_word(fmt_t'(s_cmd), s_value);
        end
        if (aresetn && m_valid && m_ready) begin
            sb.check_char(m_character, m_last);
        end
    end

    // receiver: random stall bursts plus an optional long hold-off
    always @(posedge aclk) begin
        if (sink_stall > 0) begin
            sink_stall--;
            m_ready <= 1'b0;
        end else if (long_hold) begin
            m_ready <= 1'b0;
        end else if (sink_idle_en && $urandom_range(0, 9) == 0) begin
            sink_stall = $urandom_range(0, 15);
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    task automatic send_word(fmt_t fmt, logic [VALUE_BITS-1:0] value);
        if (src_idle_en && $urandom_range(0, 4) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_cmd   <= fmt;
        s_value <= value;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic run_words(int count);
        fmt_t                  fmt;
        logic [VALUE_BITS-1:0] value;
        logic [VALUE_BITS-1:0] pow10;
        repeat (count) begin
            fmt = fmt_t'($urandom_range(0, 3));
            case ($urandom_range(0, 6))
                0: value = $urandom();
                1: value = $urandom_range(0, 999);
                2: value = -$urandom_range(1, 1000);
                3: value = 32'd1 << $urandom_range(0, 31);
                4: begin
                    pow10 = 1;
                    repeat ($urandom_range(1, 9)) pow10 = pow10 * 10;
                    value = pow10 + $urandom_range(0, 2) - 1;
                end
                5: value = $urandom() >> $urandom_range(0, 31);
                default: value = ~($urandom() >> $urandom_range(0, 31));
            endcase
            send_word(fmt, value);
        end
    endtask

    task automatic wait_for_results();
        while (sb.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    initial begin
        logic [VALUE_BITS-1:0] corner_values [5];
        corner_values[0] = 32'h0000_0000;
        corner_values[1] = 32'h0000_0001;
        corner_values[2] = 32'h7FFF_FFFF;
        corner_values[3] = 32'h8000_0000;
        corner_values[4] = 32'hFFFF_FFFF;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_cmd   = FMT_SDEC;
        s_value = '0;
        repeat (6) @(posedge aclk);
        aresetn      <= 1'b1;
        src_idle_en  <= 1'b1;
        sink_idle_en <= 1'b1;

        for (int f = 0; f < 4; f++) begin
            foreach (corner_values[i]) send_word(fmt_t'(f), corner_values[i]);
        end
        send_word(FMT_SDEC, 32'd10);
        send_word(FMT_SDEC, 32'hFFFF_FFF6);
        send_word(FMT_UDEC, 32'd1000000000);
        send_word(FMT_HEX_LO, 32'hABCD_EF09);
        send_word(FMT_HEX_UP, 32'hFEDC_BA98);
        s_valid <= 1'b0;
        wait_for_results();

        // output held off while words keep coming, so the input backs up
        long_hold   <= 1'b1;
        src_idle_en <= 1'b0;
        fork
            begin
                repeat (HOLD_CYCLES) @(posedge aclk);
                long_hold <= 1'b0;
            end
        join_none
        run_words(24);
        src_idle_en <= 1'b1;
        run_words(250);

        src_idle_en  <= 1'b0;
        sink_idle_en <= 1'b0;
        run_words(30);
        s_valid <= 1'b0;
        wait_for_results();

        $display("Summary: %0d words in signed, unsigned, lower and upper hex formats;",
                 sb.words);
        $display("         %0d characters compared, including a long output hold-off.",
                 sb.chars);
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
